[hdl/gbte_pkg.sv]
// ----------------------------------------------------------------------------
// Gap buffer text engine package
// Shared widths, status and operation codes, and the store control word.
// ----------------------------------------------------------------------------
package gbte_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned POS_W     = 7;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_OUT_W = 7;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

endpackage

[hdl/gap_buffer_text_engine.sv]
// ----------------------------------------------------------------------------
// Gap buffer text engine
// A word is taken when start is high and busy is low. One result word
// follows, marked by valid_o for one cycle, and it cannot be held off.
// A read passes through the check state and a wait for the registered read
// data. An insert that is out of range, or that finds the store full, is
// answered from the check state. Each character moved by an insert costs a
// read, whose data is registered, and then a write of the character store;
// the new character is written once the gap stands at the position.
// busy drops in the cycle valid_o rises, so the next word may start there.
// ----------------------------------------------------------------------------
module gap_buffer_text_engine import gbte_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 operation_i,
  input  logic [POS_W-1:0]     position_i,
  input  logic [CHAR_W-1:0]    char_value_i,
  output logic                 valid_o,
  output logic [STAT_W-1:0]    status_o,
  output logic [CHAR_W-1:0]    char_out_o,
  output logic [CNT_OUT_W-1:0] text_length_o,
  output logic [CNT_OUT_W-1:0] cursor_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  mem_ctrl_t         mem_ctrl;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [CHAR_W-1:0] wdata;
  logic [CHAR_W-1:0] rdata;

  gbte_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .char_value_i  (char_value_i),
    .busy          (busy),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .char_out_o    (char_out_o),
    .text_length_o (text_length_o),
    .cursor_o      (cursor_o),
    .mem_ctrl_o    (mem_ctrl),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .raddr_o       (raddr),
    .rdata_i       (rdata)
  );

  gbte_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

[hdl/gbte_store.sv]
// ----------------------------------------------------------------------------
// Gap buffer character store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module gbte_store import gbte_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic              clk_i,
  input  mem_ctrl_t         ctrl_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [CHAR_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [CHAR_W-1:0] rdata_o
);

  logic [CHAR_W-1:0] mem_q [CAPACITY];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/gbte_seq.sv]
// ----------------------------------------------------------------------------
// Gap buffer sequencer
// Holds the gap pointers, checks each word, steps the gap one character
// per read/write pair through the store, and registers the result.
// ----------------------------------------------------------------------------
module gbte_seq import gbte_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW   = $clog2(CAPACITY + 1),
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 operation_i,
  input  logic [POS_W-1:0]     position_i,
  input  logic [CHAR_W-1:0]    char_value_i,
  output logic                 busy,
  output logic                 valid_o,
  output logic [STAT_W-1:0]    status_o,
  output logic [CHAR_W-1:0]    char_out_o,
  output logic [CNT_OUT_W-1:0] text_length_o,
  output logic [CNT_OUT_W-1:0] cursor_o,
  output mem_ctrl_t            mem_ctrl_o,
  output logic [AW-1:0]        waddr_o,
  output logic [CHAR_W-1:0]    wdata_o,
  output logic [AW-1:0]        raddr_o,
  input  logic [CHAR_W-1:0]    rdata_i
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CHECK   = 6'b000010,
    S_MOVE    = 6'b000100,
    S_MOVE_WR = 6'b001000,
    S_RD_WAIT = 6'b010000,
    S_SPARE   = 6'b100000
  } state_e;

  localparam logic [CW-1:0]   CAP_C   = CW'(CAPACITY);
  localparam logic [CMPW-1:0] CAP_X_C = CMPW'(CAPACITY);

  state_e                state_q, state_d;
  logic [CW-1:0]         gs_q, gs_d, ge_q, ge_d;
  op_e                   op_q, op_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [CHAR_W-1:0]     ch_q, ch_d;
  logic                  left_q, left_d;
  logic                  valid_q, valid_d;
  status_e               status_q, status_d;
  logic [CHAR_W-1:0]     char_q, char_d;
  logic [CNT_OUT_W-1:0]  len_out_q, len_out_d;
  logic [CNT_OUT_W-1:0]  cur_q, cur_d;

  logic [CW-1:0]   gap_w, len, len_p1, gs_m1, gs_p1, ge_m1, ge_p1;
  logic [CMPW-1:0] len_x, len_p1_x, pos_x, gs_x, gs_p1_x, rd_far;

  assign gap_w    = ge_q - gs_q;
  assign len      = CAP_C - gap_w;
  assign len_p1   = len + CW'(1);
  assign gs_m1    = gs_q - CW'(1);
  assign gs_p1    = gs_q + CW'(1);
  assign ge_m1    = ge_q - CW'(1);
  assign ge_p1    = ge_q + CW'(1);
  assign len_x    = CMPW'(len);
  assign len_p1_x = CMPW'(len_p1);
  assign pos_x    = CMPW'(pos_q);
  assign gs_x     = CMPW'(gs_q);
  assign gs_p1_x  = CMPW'(gs_p1);
  assign rd_far   = pos_x + CMPW'(gap_w);

  always_comb begin
    state_d    = state_q;
    gs_d       = gs_q;
    ge_d       = ge_q;
    op_d       = op_q;
    pos_d      = pos_q;
    ch_d       = ch_q;
    left_d     = left_q;
    valid_d    = 1'b0;
    status_d   = status_q;
    char_d     = char_q;
    len_out_d  = len_out_q;
    cur_d      = cur_q;
    mem_ctrl_o = '0;
    waddr_o    = gs_q[AW-1:0];
    wdata_o    = ch_q;
    raddr_o    = ge_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d    = op_e'(operation_i);
          pos_d   = position_i;
          ch_d    = char_value_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        status_d  = STAT_RANGE;
        char_d    = '0;
        len_out_d = len_x[CNT_OUT_W-1:0];
        cur_d     = gs_x[CNT_OUT_W-1:0];
        if (op_q == OP_INSERT) begin
          if (pos_x > len_x) begin
            valid_d = 1'b1;
            state_d = S_IDLE;
          end else if (len_x >= CAP_X_C) begin
            status_d = STAT_FULL;
            valid_d  = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_MOVE;
          end
        end else begin
          if (pos_x >= len_x) begin
            valid_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            mem_ctrl_o.rd_en = 1'b1;
            raddr_o = (pos_x < gs_x) ? pos_x[AW-1:0] : rd_far[AW-1:0];
            state_d = S_RD_WAIT;
          end
        end
      end
      S_MOVE: begin
        if (gs_x > pos_x) begin
          mem_ctrl_o.rd_en = 1'b1;
          raddr_o = gs_m1[AW-1:0];
          left_d  = 1'b1;
          state_d = S_MOVE_WR;
        end else if ((gs_x < pos_x) && (ge_q < CAP_C)) begin
          mem_ctrl_o.rd_en = 1'b1;
          raddr_o = ge_q[AW-1:0];
          left_d  = 1'b0;
          state_d = S_MOVE_WR;
        end else begin
          mem_ctrl_o.wr_en = 1'b1;
          waddr_o   = gs_q[AW-1:0];
          wdata_o   = ch_q;
          gs_d      = gs_p1;
          status_d  = STAT_OK;
          char_d    = '0;
          len_out_d = len_p1_x[CNT_OUT_W-1:0];
          cur_d     = gs_p1_x[CNT_OUT_W-1:0];
          valid_d   = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_MOVE_WR: begin
        mem_ctrl_o.wr_en = 1'b1;
        wdata_o = rdata_i;
        if (left_q) begin
          waddr_o = ge_m1[AW-1:0];
          gs_d    = gs_m1;
          ge_d    = ge_m1;
        end else begin
          waddr_o = gs_q[AW-1:0];
          gs_d    = gs_p1;
          ge_d    = ge_p1;
        end
        state_d = S_MOVE;
      end
      S_RD_WAIT: begin
        status_d  = STAT_OK;
        char_d    = rdata_i;
        len_out_d = len_x[CNT_OUT_W-1:0];
        cur_d     = gs_x[CNT_OUT_W-1:0];
        valid_d   = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      gs_q    <= '0;
      ge_q    <= CAP_C;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      gs_q    <= gs_d;
      ge_q    <= ge_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    pos_q     <= pos_d;
    ch_q      <= ch_d;
    left_q    <= left_d;
    status_q  <= status_d;
    char_q    <= char_d;
    len_out_q <= len_out_d;
    cur_q     <= cur_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign char_out_o    = char_q;
  assign text_length_o = len_out_q;
  assign cursor_o      = cur_q;

endmodule
